/* rtl/epmd_pkg.sv */
// ----------------------------------------------------------------------------
// epmd_pkg
// Shared widths, register indexes and the multiply-accumulate op word for
// the edge point median deviation filter.
// ----------------------------------------------------------------------------
package epmd_pkg;

  localparam int COORD_W   = 24;
  localparam int MAXDEV_W  = 23;
  localparam int CFG_IDX_W = 3;
  localparam int DIFF_W    = 25;   // coordinate difference
  localparam int OFF_W     = 50;   // cross product offset
  localparam int MED_W     = 51;   // median at double scale
  localparam int AD_W      = 52;   // magnitude of deviation, squared operands
  localparam int HALF_W    = 26;   // operand half for wide products
  localparam int MUL_W     = 27;   // signed multiplier operand
  localparam int PROD_W    = 54;
  localparam int ACC_W     = 106;

  localparam logic [CFG_IDX_W-1:0] REG_GUIDE_START_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GUIDE_START_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GUIDE_END_X   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GUIDE_END_Y   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DEVIATION = 3'd4;

  localparam logic [1:0] SH_0  = 2'd0;
  localparam logic [1:0] SH_26 = 2'd1;
  localparam logic [1:0] SH_52 = 2'd2;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic       valid;
    logic       clear;
    logic       sub;
    logic [1:0] shift;
  } mac_op_t;

endpackage

/* rtl/epmd_if.sv */
// ----------------------------------------------------------------------------
// epmd interfaces
// Point input, result output and register write channels.
// ----------------------------------------------------------------------------
interface epmd_pt_if;
  import epmd_pkg::*;
  logic   valid;
  logic   ready;
  coord_t point_x;
  coord_t point_y;
  logic   last_point;
  modport source (output valid, point_x, point_y, last_point, input ready);
  modport sink (input valid, point_x, point_y, last_point, output ready);
endinterface

interface epmd_res_if;
  import epmd_pkg::*;
  logic   valid;
  logic   ready;
  coord_t kept_x;
  coord_t kept_y;
  logic   last_result;
  logic   none_kept;
  logic   overflowed;
  modport source (output valid, kept_x, kept_y, last_result, none_kept, overflowed,
                  input ready);
  modport sink (input valid, kept_x, kept_y, last_result, none_kept, overflowed,
                output ready);
endinterface

interface epmd_cfg_if;
  import epmd_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] addr;
  logic [COORD_W-1:0]   data;
  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

/* rtl/epmd_mac.sv */
// ----------------------------------------------------------------------------
// epmd_mac
// Shared signed 27x27 multiplier with a registered product and a shifted
// 106-bit accumulator behind it.
// ----------------------------------------------------------------------------
module epmd_mac (
  input  logic                           clk,
  input  logic                           rst,
  input  epmd_pkg::mac_op_t              op,
  input  logic signed [epmd_pkg::MUL_W-1:0] a,
  input  logic signed [epmd_pkg::MUL_W-1:0] b,
  output logic signed [epmd_pkg::ACC_W-1:0] acc
);
  import epmd_pkg::*;

  logic signed [PROD_W-1:0] prod;
  mac_op_t                  op1;
  logic signed [ACC_W-1:0]  ext;
  logic signed [ACC_W-1:0]  term;
  logic signed [ACC_W-1:0]  base;

  always_ff @(posedge clk) begin
    if (rst) begin
      op1 <= '0;
    end else begin
      op1 <= op;
    end
  end

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

  always_comb begin
    ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
    unique case (op1.shift)
      SH_0:    term = ext;
      SH_26:   term = ext <<< 26;
      SH_52:   term = ext <<< 52;
      default: term = ext;
    endcase
    base = op1.clear ? '0 : acc;
  end

  always_ff @(posedge clk) begin
    if (op1.valid) begin
      acc <= op1.sub ? base - term : base + term;
    end
  end

endmodule

/* rtl/edge_point_median_deviation_filter.sv */
// ----------------------------------------------------------------------------
// edge_point_median_deviation_filter
// Stores a set of edge points, ranks their guide line offsets to find the
// median and passes on the points that lie within max_deviation of it.
// ----------------------------------------------------------------------------
// Loading takes one point per cycle; the block is ready only while loading.
// After the last point come setup, offsets per point, the rank-count median
// and a squared test per point, in turn on the one shared multiply-accumulate
// unit and the offset store port. A set of under three points, a zero
// max_deviation or a guide with coincident ends passes through unfiltered.
// Output stalls hold the test and pass-through steps. Reset clears control
// state and configuration registers, not the point and offset stores.
module edge_point_median_deviation_filter #(
  parameter int MAX_POINTS = 64
) (
  input  logic         clk,
  input  logic         rst,
  epmd_pt_if.sink      pt_in,
  epmd_res_if.source   res_out,
  epmd_cfg_if.sink     cfg
);
  import epmd_pkg::*;

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_POINTS);
  localparam logic [CW-1:0] CNT_MIN = CW'(3);

  localparam logic [3:0] ST_LOAD = 4'd0;
  localparam logic [3:0] ST_PREP = 4'd1;
  localparam logic [3:0] ST_OFF  = 4'd2;
  localparam logic [3:0] ST_MA   = 4'd3;
  localparam logic [3:0] ST_MB   = 4'd4;
  localparam logic [3:0] ST_MC   = 4'd5;
  localparam logic [3:0] ST_MD   = 4'd6;
  localparam logic [3:0] ST_FLT  = 4'd7;
  localparam logic [3:0] ST_END  = 4'd8;
  localparam logic [3:0] ST_PASS = 4'd9;

  // configuration
  coord_t                gsx, gsy, gex, gey;
  logic [MAXDEV_W-1:0]   max_dev;

  // control
  logic [3:0]            state;
  logic [3:0]            step;
  logic [AW-1:0]         idx, idx_next, jdx;
  logic [CW-1:0]         count, cnt_new, cnt_m1, lt, le, klo, khi;
  logic                  ovf;

  // datapath
  logic [2*COORD_W-1:0]  pmem [MAX_POINTS];
  logic [OFF_W-1:0]      omem [MAX_POINTS];
  logic [2*COORD_W-1:0]  pdata;
  logic signed [OFF_W-1:0] odata, vj, mlo, mhi;
  logic signed [MED_W-1:0] med2;
  logic signed [AD_W-1:0]  dval;
  logic [AD_W-1:0]       ad, len2, md2;
  logic signed [ACC_W-1:0] rhs, acc;
  logic signed [DIFF_W-1:0] ax, ay, dx, dy;
  coord_t                px, py;

  logic                  pend_v;
  coord_t                pend_x, pend_y;

  mac_op_t               mop;
  logic signed [MUL_W-1:0] ma, mb;

  logic accept, last_idx, jlast, out_free, pass, keep, flt_go;
  logic emit_do, emit_last, emit_none;
  coord_t emit_x, emit_y;

  function automatic logic signed [MUL_W-1:0] sx(input logic signed [DIFF_W-1:0] v);
    sx = {{(MUL_W-DIFF_W){v[DIFF_W-1]}}, v};
  endfunction

  function automatic logic signed [MUL_W-1:0] zx(input logic [HALF_W-1:0] v);
    zx = {1'b0, v};
  endfunction

  assign pt_in.ready = (state == ST_LOAD);
  assign cfg.ready   = 1'b1;

  assign accept   = pt_in.valid && pt_in.ready;
  assign out_free = !res_out.valid || res_out.ready;
  assign cnt_m1   = count - CW'(1);
  assign last_idx = (CW'(idx) == cnt_m1);
  assign jlast    = (CW'(jdx) == cnt_m1);
  assign cnt_new  = (count < CNT_MAX) ? count + CW'(1) : count;
  assign klo      = cnt_m1 >> 1;
  assign khi      = count >> 1;

  assign px = pdata[2*COORD_W-1:COORD_W];
  assign py = pdata[COORD_W-1:0];
  assign ax = {gex[COORD_W-1], gex} - {gsx[COORD_W-1], gsx};
  assign ay = {gey[COORD_W-1], gey} - {gsy[COORD_W-1], gsy};
  assign dx = {px[COORD_W-1], px} - {gsx[COORD_W-1], gsx};
  assign dy = {py[COORD_W-1], py} - {gsy[COORD_W-1], gsy};

  assign pass = (cnt_new < CNT_MIN) || (max_dev == '0) || (ax == '0 && ay == '0);
  assign dval = {odata[OFF_W-1], odata, 1'b0} - {med2[MED_W-1], med2};
  assign keep = (acc <= rhs);
  assign flt_go = (state == ST_FLT) && (step == 4'd6) && (!keep || !pend_v || out_free);

  // read address for both stores
  always_comb begin
    idx_next = idx;
    unique case (state)
      ST_LOAD: if (accept && pt_in.last_point) idx_next = '0;
      ST_PREP: if (step == 4'd11) idx_next = '0;
      ST_OFF:  if (step == 4'd3) idx_next = last_idx ? '0 : idx + AW'(1);
      ST_MA:   idx_next = '0;
      ST_MB:   idx_next = last_idx ? jdx : idx + AW'(1);
      ST_MC:   idx_next = jlast ? '0 : jdx + AW'(1);
      ST_MD:   idx_next = '0;
      ST_FLT:  if (flt_go) idx_next = idx + AW'(1);
      ST_END:  idx_next = idx;
      ST_PASS: if (step == 4'd1 && out_free) idx_next = idx + AW'(1);
      default: idx_next = idx;
    endcase
  end

  // shared multiplier schedule
  always_comb begin
    mop = '0;
    ma  = '0;
    mb  = '0;
    if (state == ST_PREP) begin
      unique case (step)
        4'd0: begin mop = '{1'b1, 1'b1, 1'b0, SH_0};  ma = sx(ax); mb = sx(ax); end
        4'd1: begin mop = '{1'b1, 1'b0, 1'b0, SH_0};  ma = sx(ay); mb = sx(ay); end
        4'd3: begin
          mop = '{1'b1, 1'b1, 1'b0, SH_0};
          ma  = {{(MUL_W-MAXDEV_W){1'b0}}, max_dev};
          mb  = {{(MUL_W-MAXDEV_W){1'b0}}, max_dev};
        end
        4'd6: begin
          mop = '{1'b1, 1'b1, 1'b0, SH_0};
          ma = zx(md2[HALF_W-1:0]); mb = zx(len2[HALF_W-1:0]);
        end
        4'd7: begin
          mop = '{1'b1, 1'b0, 1'b0, SH_26};
          ma = zx(md2[HALF_W-1:0]); mb = zx(len2[AD_W-1:HALF_W]);
        end
        4'd8: begin
          mop = '{1'b1, 1'b0, 1'b0, SH_26};
          ma = zx(md2[AD_W-1:HALF_W]); mb = zx(len2[HALF_W-1:0]);
        end
        4'd9: begin
          mop = '{1'b1, 1'b0, 1'b0, SH_52};
          ma = zx(md2[AD_W-1:HALF_W]); mb = zx(len2[AD_W-1:HALF_W]);
        end
        default: mop = '0;
      endcase
    end else if (state == ST_OFF) begin
      unique case (step)
        4'd0: begin mop = '{1'b1, 1'b1, 1'b0, SH_0}; ma = sx(dy); mb = sx(ax); end
        4'd1: begin mop = '{1'b1, 1'b0, 1'b1, SH_0}; ma = sx(dx); mb = sx(ay); end
        default: mop = '0;
      endcase
    end else if (state == ST_FLT) begin
      unique case (step)
        4'd1: begin
          mop = '{1'b1, 1'b1, 1'b0, SH_0};
          ma = zx(ad[HALF_W-1:0]); mb = zx(ad[HALF_W-1:0]);
        end
        4'd2: begin
          mop = '{1'b1, 1'b0, 1'b0, SH_26};
          ma = zx(ad[HALF_W-1:0]); mb = zx(ad[AD_W-1:HALF_W]);
        end
        4'd3: begin
          mop = '{1'b1, 1'b0, 1'b0, SH_26};
          ma = zx(ad[AD_W-1:HALF_W]); mb = zx(ad[HALF_W-1:0]);
        end
        4'd4: begin
          mop = '{1'b1, 1'b0, 1'b0, SH_52};
          ma = zx(ad[AD_W-1:HALF_W]); mb = zx(ad[AD_W-1:HALF_W]);
        end
        default: mop = '0;
      endcase
    end
  end

  epmd_mac u_mac (
    .clk (clk),
    .rst (rst),
    .op  (mop),
    .a   (ma),
    .b   (mb),
    .acc (acc)
  );

  // result word selection
  always_comb begin
    emit_do   = 1'b0;
    emit_x    = pend_x;
    emit_y    = pend_y;
    emit_last = 1'b0;
    emit_none = 1'b0;
    priority if (flt_go && keep && pend_v) begin
      emit_do = 1'b1;
    end else if (state == ST_END && out_free) begin
      emit_do   = 1'b1;
      emit_last = 1'b1;
      if (!pend_v) begin
        emit_none = 1'b1;
        emit_x    = '0;
        emit_y    = '0;
      end
    end else if (state == ST_PASS && step == 4'd1 && out_free) begin
      emit_do   = 1'b1;
      emit_x    = px;
      emit_y    = py;
      emit_last = last_idx;
    end else begin
      emit_do = 1'b0;
    end
  end

  // stores
  always_ff @(posedge clk) begin
    if (accept && count < CNT_MAX) begin
      pmem[count[AW-1:0]] <= {pt_in.point_x, pt_in.point_y};
    end
    pdata <= pmem[idx_next];
  end

  always_ff @(posedge clk) begin
    if (state == ST_OFF && step == 4'd3) begin
      omem[idx] <= acc[OFF_W-1:0];
    end
    odata <= omem[idx_next];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_out.valid <= 1'b0;
    end else if (emit_do) begin
      res_out.valid <= 1'b1;
    end else if (res_out.ready) begin
      res_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_do) begin
      res_out.kept_x      <= emit_x;
      res_out.kept_y      <= emit_y;
      res_out.last_result <= emit_last;
      res_out.none_kept   <= emit_none;
      res_out.overflowed  <= ovf;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gsx     <= '0;
      gsy     <= '0;
      gex     <= '0;
      gey     <= '0;
      max_dev <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.addr)
        REG_GUIDE_START_X: gsx <= cfg.data;
        REG_GUIDE_START_Y: gsy <= cfg.data;
        REG_GUIDE_END_X:   gex <= cfg.data;
        REG_GUIDE_END_Y:   gey <= cfg.data;
        REG_MAX_DEVIATION: max_dev <= cfg.data[MAXDEV_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_LOAD;
      step   <= '0;
      count  <= '0;
      ovf    <= 1'b0;
      pend_v <= 1'b0;
      jdx    <= '0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (accept) begin
            count <= cnt_new;
            if (count == CNT_MAX) ovf <= 1'b1;
            if (pt_in.last_point) begin
              step  <= '0;
              state <= pass ? ST_PASS : ST_PREP;
            end
          end
        end
        ST_PREP: begin
          step <= step + 4'd1;
          if (step == 4'd3) len2 <= acc[AD_W-1:0];
          if (step == 4'd5) md2 <= {acc[AD_W-3:0], 2'b00};
          if (step == 4'd11) begin
            rhs   <= acc;
            step  <= '0;
            state <= ST_OFF;
          end
        end
        ST_OFF: begin
          step <= step + 4'd1;
          if (step == 4'd3) begin
            step <= '0;
            if (last_idx) begin
              jdx   <= '0;
              state <= ST_MA;
            end
          end
        end
        ST_MA: begin
          vj    <= odata;
          lt    <= '0;
          le    <= '0;
          state <= ST_MB;
        end
        ST_MB: begin
          if (odata < vj)  lt <= lt + CW'(1);
          if (odata <= vj) le <= le + CW'(1);
          if (last_idx) state <= ST_MC;
        end
        ST_MC: begin
          if (lt <= klo && klo < le) mlo <= vj;
          if (lt <= khi && khi < le) mhi <= vj;
          jdx   <= jdx + AW'(1);
          state <= jlast ? ST_MD : ST_MA;
        end
        ST_MD: begin
          med2  <= {mlo[OFF_W-1], mlo} + {mhi[OFF_W-1], mhi};
          step  <= '0;
          state <= ST_FLT;
        end
        ST_FLT: begin
          if (step == 4'd0) ad <= dval[AD_W-1] ? AD_W'(-dval) : AD_W'(dval);
          if (step != 4'd6) begin
            step <= step + 4'd1;
          end else if (flt_go) begin
            // hold the kept point until the next one shows whether it is last
            if (keep) begin
              pend_v <= 1'b1;
              pend_x <= px;
              pend_y <= py;
            end
            step <= '0;
            if (last_idx) state <= ST_END;
          end
        end
        ST_END: begin
          if (out_free) begin
            pend_v <= 1'b0;
            count  <= '0;
            ovf    <= 1'b0;
            state  <= ST_LOAD;
          end
        end
        ST_PASS: begin
          if (step == 4'd0) begin
            step <= 4'd1;
          end else if (out_free) begin
            step <= '0;
            if (last_idx) begin
              count <= '0;
              ovf   <= 1'b0;
              state <= ST_LOAD;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

endmodule

/* rtl/epmd_check.sv */
// ----------------------------------------------------------------------------
// epmd_check
// Port-level checks for the edge point median deviation filter.
// ----------------------------------------------------------------------------
module epmd_check (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [epmd_pkg::COORD_W-1:0] out_x,
  input logic [epmd_pkg::COORD_W-1:0] out_y,
  input logic                     out_last,
  input logic                     out_none
);
  import epmd_pkg::*;

  // a stalled word stays
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_none_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_none |-> out_last)
    else $error("empty result not marked last");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_none |-> (out_x == '0 && out_y == '0))
    else $error("empty result carries coordinates");

  a_ready_after_rst: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> in_ready)
    else $error("not ready for points after reset");

  // a stalled word keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_x) && $stable(out_y) &&
                                $stable(out_last) && $stable(out_none))
    else $error("result word changed while stalled");

endmodule

bind edge_point_median_deviation_filter epmd_check u_epmd_check (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (pt_in.ready),
  .out_valid (res_out.valid),
  .out_ready (res_out.ready),
  .out_x     (res_out.kept_x),
  .out_y     (res_out.kept_y),
  .out_last  (res_out.last_result),
  .out_none  (res_out.none_kept)
);

/* tb/edge_point_median_deviation_filter_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_point_median_deviation_filter_checker
// Watches the register, point and result channels. Keeps its own copy of the
// guide line settings and of the stored set. When a set closes it works out
// the kept points and compares them, in order, with the words on the output.
// ----------------------------------------------------------------------------
module edge_point_median_deviation_filter_checker #(
  parameter int MAX_POINTS = 64
) (
  input  logic clk,
  input  logic rst,
  epmd_pt_if   pt,
  epmd_res_if  res,
  epmd_cfg_if  cfg,
  output int   failures,
  output int   pending
);
  import epmd_pkg::*;

  typedef struct {
    coord_t x;
    coord_t y;
    bit     last;
    bit     none;
    bit     ovf;
  } kept_word_t;

  kept_word_t kept_q[$];

  longint start_x, start_y, end_x, end_y;
  longint max_dev;

  longint set_x[MAX_POINTS];
  longint set_y[MAX_POINTS];
  int     set_len;
  bit     set_ovf;

  assign pending = kept_q.size();

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    failures++;
  endtask

  task automatic push_word(input longint x, input longint y, input bit last,
                           input bit none);
    kept_word_t w;
    w.x = coord_t'(x);
    w.y = coord_t'(y);
    w.last = last;
    w.none = none;
    w.ovf = set_ovf;
    kept_q.insert(kept_q.size(), w);
  endtask

  // judge the closed set and queue the kept points
  task automatic judge_set();
    longint ax, ay, dx, dy, v, med2, d;
    longint offs[MAX_POINTS];
    longint sorted[MAX_POINTS];
    logic [127:0] lhs, rhs, md2, len2, ad;
    int j, kept;
    bit thru;
    ax = end_x - start_x;
    ay = end_y - start_y;
    thru = (set_len < 3) || (max_dev == 0) || (ax == 0 && ay == 0);
    if (thru) begin
      for (int i = 0; i < set_len; i++)
        push_word(set_x[i], set_y[i], i + 1 == set_len, 1'b0);
    end else begin
      for (int i = 0; i < set_len; i++) begin
        dx = set_x[i] - start_x;
        dy = set_y[i] - start_y;
        offs[i] = dy * ax - dx * ay;
        sorted[i] = offs[i];
      end
      for (int i = 1; i < set_len; i++) begin
        v = sorted[i];
        j = i;
        while (j > 0 && sorted[j-1] > v) begin
          sorted[j] = sorted[j-1];
          j--;
        end
        sorted[j] = v;
      end
      if (set_len % 2 == 1)
        med2 = 2 * sorted[set_len/2];
      else
        med2 = sorted[set_len/2 - 1] + sorted[set_len/2];
      md2 = 128'(max_dev) * 128'(max_dev) * 128'd4;
      len2 = 128'(ax * ax) + 128'(ay * ay);
      rhs = md2 * len2;
      kept = 0;
      for (int i = 0; i < set_len; i++) begin
        d = 2 * offs[i] - med2;
        ad = 128'(d < 0 ? -d : d);
        lhs = ad * ad;
        if (lhs <= rhs) begin
          push_word(set_x[i], set_y[i], 1'b0, 1'b0);
          kept++;
        end
      end
      if (kept == 0)
        push_word(0, 0, 1'b1, 1'b1);
      else
        kept_q[kept_q.size()-1].last = 1'b1;
    end
    set_len = 0;
    set_ovf = 0;
  endtask

  always @(posedge clk) begin
    kept_word_t w;
    if (rst) begin
      start_x = 0; start_y = 0; end_x = 0; end_y = 0; max_dev = 0;
      set_len = 0;
      set_ovf = 0;
      failures = failures;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.addr)
          REG_GUIDE_START_X: start_x = longint'(coord_t'(cfg.data));
          REG_GUIDE_START_Y: start_y = longint'(coord_t'(cfg.data));
          REG_GUIDE_END_X:   end_x = longint'(coord_t'(cfg.data));
          REG_GUIDE_END_Y:   end_y = longint'(coord_t'(cfg.data));
          REG_MAX_DEVIATION: max_dev = longint'(cfg.data[MAXDEV_W-1:0]);
          default: ;
        endcase
      end
      if (res.valid && res.ready) begin
        if (kept_q.size() == 0) begin
          report("unexpected result word", 1, 0);
        end else begin
          w = kept_q.pop_front();
          if (res.none_kept != w.none) report("none_kept", res.none_kept, w.none);
          if (res.last_result != w.last) report("last_result", res.last_result, w.last);
          if (res.overflowed != w.ovf) report("overflowed", res.overflowed, w.ovf);
          if (!w.none) begin
            if (res.kept_x != w.x) report("kept_x", res.kept_x, w.x);
            if (res.kept_y != w.y) report("kept_y", res.kept_y, w.y);
          end
        end
      end
      if (pt.valid && pt.ready) begin
        if (set_len < MAX_POINTS) begin
          set_x[set_len] = longint'(pt.point_x);
          set_y[set_len] = longint'(pt.point_y);
          set_len++;
        end else begin
          set_ovf = 1;
        end
        if (pt.last_point) judge_set();
      end
    end
  end

  initial failures = 0;

endmodule

/* tb/edge_point_median_deviation_filter_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_point_median_deviation_filter_tb
// Feeds point sets near and away from a guide line under many guide and
// deviation settings, with random gaps on both channels, an output hold-off
// that backs up the input, and over-capacity sets. The checker predicts the
// kept points and counts mismatches.
// ----------------------------------------------------------------------------
module edge_point_median_deviation_filter_tb;
  import epmd_pkg::*;

  localparam int NPTS = 64;

  logic clk;
  logic rst;
  int   failures;
  int   pending;
  int   items;
  bit   steady;      // no gaps on either side
  bit   hold_start;  // ask the receiver for one long hold-off
  longint g_sx, g_sy, g_ex, g_ey, g_dev;

  epmd_pt_if  pt_ch();
  epmd_res_if res_ch();
  epmd_cfg_if cfg_ch();

  edge_point_median_deviation_filter #(.MAX_POINTS(NPTS)) uut (
    .clk(clk), .rst(rst), .pt_in(pt_ch.sink), .res_out(res_ch.source), .cfg(cfg_ch.sink)
  );

  edge_point_median_deviation_filter_checker #(.MAX_POINTS(NPTS)) chk (
    .clk(clk), .rst(rst), .pt(pt_ch), .res(res_ch), .cfg(cfg_ch),
    .failures(failures), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4ms;
    $display("*** FAILED ***");
    $finish;
  end

  // result receiver: random hold per word, one long hold on request
  initial begin
    int w;
    res_ch.ready = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_start) begin
        hold_start = 0;
        res_ch.ready <= 0;
        repeat (600) @(negedge clk);
      end
      w = steady ? 0 : $urandom_range(0, 6);
      if (w > 0) begin
        res_ch.ready <= 0;
        repeat (w) @(negedge clk);
      end
      res_ch.ready <= 1;
      @(posedge clk);
      while (!res_ch.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic send_point(input longint x, input longint y, input bit last);
    int w;
    w = steady ? 0 : $urandom_range(0, 6);
    if (w > 0) begin
      pt_ch.valid <= 0;
      repeat (w) @(negedge clk);
    end
    pt_ch.valid <= 1;
    pt_ch.point_x <= coord_t'(x);
    pt_ch.point_y <= coord_t'(y);
    pt_ch.last_point <= last;
    @(posedge clk);
    while (!pt_ch.ready) @(posedge clk);
    @(negedge clk);
    items++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint value);
    cfg_ch.valid <= 1;
    cfg_ch.addr <= idx;
    cfg_ch.data <= COORD_W'(value);
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 0;
  endtask

  // let every expected word arrive, then let the block settle
  task automatic drain();
    pt_ch.valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic set_guide(input longint sx, input longint sy, input longint ex,
                           input longint ey, input longint dev);
    g_sx = sx; g_sy = sy; g_ex = ex; g_ey = ey; g_dev = dev;
    write_reg(REG_GUIDE_START_X, sx);
    write_reg(REG_GUIDE_START_Y, sy);
    write_reg(REG_GUIDE_END_X, ex);
    write_reg(REG_GUIDE_END_Y, ey);
    write_reg(REG_MAX_DEVIATION, dev);
  endtask

  // random set: mostly points near the guide, some outliers and noise
  task automatic send_set(input int n);
    longint t, x, y, spread;
    spread = longint'($urandom_range(0, 3000));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        x = longint'($urandom());
        y = longint'($urandom());
      end else begin
        t = longint'($urandom_range(0, 256));
        x = g_sx + (g_ex - g_sx) * t / 256;
        y = g_sy + (g_ey - g_sy) * t / 256;
        if ($urandom_range(0, 5) == 0) begin
          x += longint'($urandom_range(0, 40000)) - 20000;
          y += longint'($urandom_range(0, 40000)) - 20000;
        end else begin
          x += longint'($urandom_range(0, 2 * spread)) - spread;
          y += longint'($urandom_range(0, 2 * spread)) - spread;
        end
      end
      send_point(x, y, i == n - 1);
    end
  endtask

  function automatic longint rand_coord();
    return longint'($urandom_range(0, 1 << 19)) - (1 << 18);
  endfunction

  initial begin
    int n, pick;
    rst = 1;
    items = 0;
    steady = 0;
    hold_start = 0;
    pt_ch.valid = 0;
    pt_ch.point_x = 0;
    pt_ch.point_y = 0;
    pt_ch.last_point = 0;
    cfg_ch.valid = 0;
    cfg_ch.addr = '0;
    cfg_ch.data = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // horizontal guide, one pixel tolerance: a far point is rejected
    set_guide(0, 0, 256, 0, 256);
    send_point(0, 0, 0);
    send_point(256, 50, 0);
    send_point(512, -40, 0);
    send_point(768, 2000, 0);
    send_point(1024, 0, 1);
    drain();
    // two middle offsets far apart: nothing kept
    write_reg(REG_MAX_DEVIATION, 1);
    send_point(0, 0, 0);
    send_point(10, 0, 0);
    send_point(20, 10000, 0);
    send_point(30, 10000, 1);
    // fewer than three points pass through
    send_point(8388607, -8388608, 1);
    send_point(-8388608, 8388607, 0);
    send_point(-1, 0, 1);
    drain();
    // zero tolerance passes through
    write_reg(REG_MAX_DEVIATION, 0);
    send_point(5, 7, 0);
    send_point(-900000, 3, 0);
    send_point(42, 8388607, 1);
    drain();
    // coincident guide ends pass through
    set_guide(-8388608, 8388607, -8388608, 8388607, 8388607);
    send_point(1, 2, 0);
    send_point(8388607, 8388607, 0);
    send_point(-8388608, -8388608, 1);
    drain();
    // guide across the full range
    set_guide(-8388608, 8388607, 8388607, -8388608, 8388607);
    send_point(8388607, 8388607, 0);
    send_point(-8388608, -8388608, 0);
    send_point(0, 0, 0);
    send_point(8388607, -8388608, 1);
    drain();

    // over capacity: two points dropped, one of them the last
    set_guide(0, 0, 4096, 1024, 512);
    send_set(NPTS + 2);
    drain();

    // long output hold while sets keep coming: input must stall
    hold_start = 1;
    send_set(6);
    send_set(5);
    send_set(4);
    drain();

    while (items < 360) begin
      if ($urandom_range(0, 3) == 0) begin
        // registers change only with nothing in flight
        drain();
        pick = $urandom_range(0, 9);
        if (pick == 0)
          set_guide(rand_coord(), rand_coord(), rand_coord(), rand_coord(), 0);
        else if (pick == 1)
          set_guide(g_sx, g_sy, g_sx, g_sy, longint'($urandom_range(1, 4096)));
        else if (pick == 2)
          set_guide(rand_coord(), rand_coord(), rand_coord(), rand_coord(), 8388607);
        else
          set_guide(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                    longint'($urandom_range(1, 4096)));
      end
      steady = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 24);
      if (pick == 0) n = NPTS;
      else if (pick < 3) n = $urandom_range(1, 2);
      else n = $urandom_range(3, 12);
      send_set(n);
      if ($urandom_range(0, 2) == 0) drain();
    end
    steady = 0;
    drain();

    if (failures == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

/* sim.f */
rtl/epmd_pkg.sv
rtl/epmd_if.sv
rtl/epmd_mac.sv
rtl/edge_point_median_deviation_filter.sv
rtl/epmd_check.sv
tb/edge_point_median_deviation_filter_checker.sv
tb/edge_point_median_deviation_filter_tb.sv
